[hw/rtl/binary_image_thinning_assert.svh]
// Assertion macros shared by the thinning block.
`ifndef BINARY_IMAGE_THINNING_ASSERT_SVH
`define BINARY_IMAGE_THINNING_ASSERT_SVH
`ifndef SYNTHESIS
`define BIT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BIT_ASSERT_IMP(label, clk, rst, ante, cons)
`define BIT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/bit_pkg.sv]
// Types and constants of the thinning block.
`default_nettype none
package bit_pkg;
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_HAM   = 2'd2,
      CMD_THIN  = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_KERNEL = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDPIX, ST_RDWAIT, ST_COPY, ST_COPYW,
      ST_PIX, ST_NBR, ST_NBRW, ST_WR, ST_PASSEND, ST_DONE
   } state_type;

   // Sub-pass kernels, cell (dx+1)*3+(dy+1) at bits 2*cell+1..2*cell.
   function automatic logic [17:0] thin_kernel(input logic [2:0] k);
      logic [17:0] r;
      begin
         unique case (k)
            3'd0: r = {2'd0,2'd0,2'd0,2'd2,2'd1,2'd2,2'd1,2'd1,2'd1};
            3'd1: r = {2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd0,2'd0,2'd0};
            3'd2: r = {2'd0,2'd2,2'd1,2'd0,2'd1,2'd1,2'd0,2'd2,2'd1};
            3'd3: r = {2'd1,2'd2,2'd0,2'd1,2'd1,2'd0,2'd1,2'd2,2'd0};
            3'd4: r = {2'd0,2'd0,2'd2,2'd0,2'd1,2'd1,2'd2,2'd1,2'd2};
            3'd5: r = {2'd2,2'd0,2'd0,2'd1,2'd1,2'd0,2'd2,2'd1,2'd2};
            3'd6: r = {2'd2,2'd1,2'd2,2'd1,2'd1,2'd0,2'd2,2'd0,2'd0};
            default: r = {2'd2,2'd1,2'd2,2'd0,2'd1,2'd1,2'd0,2'd0,2'd2};
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

[hw/rtl/binary_image_thinning.sv]
// Top level of the binary image thinning block.
//
// Channel   Ports                                       Direction
// command   start, req_command/column/row/pixel_value   in; busy out
// result    rsp_valid, rsp_pixel_out, rsp_image_changed     out
// config    csr_write, csr_index, csr_data                  in
//
// Busy stays high while a write or read runs; the result word is valid in the
// first cycle in which busy is low.
// A pass copies the image into the snapshot store, then walks the neighbours
// of each pixel and writes it back, and ends in a closing state; each image
// store has a single read port.
// Thinning runs 8 passes per round until a round changes nothing.
// Reset clears control state and loads the default configuration only; the image stores hold nothing until written.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
`include "binary_image_thinning_assert.svh"
module binary_image_thinning #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_column,
   input  wire logic [7:0]  req_row,
   input  wire logic        req_pixel_value,
   output logic             rsp_valid,
   output logic             rsp_pixel_out,
   output logic             rsp_image_changed,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [17:0] csr_data
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;
   localparam int SW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   bit_pkg::state_type state_ff, state_in;
   logic [8:0]  width_ff, height_ff;
   logic [17:0] kernel_ff, cur_kernel;
   logic [1:0]  cmd_ff;
   logic [XW-1:0] x_ff, x_in, nx;
   logic [YW-1:0] y_ff, y_in, ny;
   logic [3:0]  cell_ff, cell_in;
   logic [2:0]  sub_ff, sub_in;
   logic        match_ff, match_in, old_ff, old_in;
   logic        any_ff, any_in, round_changed_ff, round_changed_in;
   logic        pix_ff, pix_in;
   logic        in_area_ff;
   logic [7:0]  col_ff, row_ff;
   logic        val_ff;
   logic [SW-1:0] w_act;
   logic [HW-1:0] h_act;
   logic [XW-1:0] wm1;
   logic [YW-1:0] hm1;
   logic        x_last, y_last;
   logic [1:0]  code;
   logic [1:0]  dxi, dyi;
   logic        img_we, snp_we, img_rd, snp_rd, img_wd, nv;
   logic [AW-1:0] img_addr, snp_addr;
   logic        rsp_valid_in;

   // Saturated active size.
   always_comb begin
      if (width_ff == 9'd0) w_act = SW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_act = SW'(MAX_WIDTH);
      else w_act = SW'(width_ff);
      if (height_ff == 9'd0) h_act = HW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_act = HW'(MAX_HEIGHT);
      else h_act = HW'(height_ff);
   end
   assign wm1 = XW'(w_act - SW'(1));
   assign hm1 = YW'(h_act - HW'(1));
   assign x_last = (x_ff == wm1);
   assign y_last = (y_ff == hm1);

   // Kernel of the current pass and the cell under test.
   assign cur_kernel = (cmd_ff == bit_pkg::CMD_HAM) ? kernel_ff :
                       bit_pkg::thin_kernel(sub_ff);
   assign code = (cell_ff < 4'd9) ? cur_kernel[2*cell_ff +: 2] : 2'd2;
   always_comb begin
      unique case (cell_ff)
         4'd0, 4'd1, 4'd2: dxi = 2'd0;
         4'd3, 4'd4, 4'd5: dxi = 2'd1;
         default:          dxi = 2'd2;
      endcase
      unique case (cell_ff)
         4'd0, 4'd3, 4'd6: dyi = 2'd0;
         4'd1, 4'd4, 4'd7: dyi = 2'd1;
         default:          dyi = 2'd2;
      endcase
      if (dxi == 2'd0) nx = (x_ff == '0) ? wm1 : x_ff - XW'(1);
      else if (dxi == 2'd2) nx = x_last ? '0 : x_ff + XW'(1);
      else nx = x_ff;
      if (dyi == 2'd0) ny = (y_ff == '0) ? hm1 : y_ff - YW'(1);
      else if (dyi == 2'd2) ny = y_last ? '0 : y_ff + YW'(1);
      else ny = y_ff;
   end
   assign nv = (cmd_ff == bit_pkg::CMD_HAM) ? match_ff : (old_ff & ~match_ff);

   // Configuration and accepted command.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         kernel_ff <= 18'd174762;
      end else if (csr_write) begin
         unique case (csr_index)
            bit_pkg::CSR_WIDTH:  width_ff  <= csr_data[8:0];
            bit_pkg::CSR_HEIGHT: height_ff <= csr_data[8:0];
            bit_pkg::CSR_KERNEL: kernel_ff <= csr_data;
            default: ;
         endcase
      end
      if (start && !busy) begin
         cmd_ff <= req_command;
         col_ff <= req_column;
         row_ff <= req_row;
         val_ff <= req_pixel_value;
         in_area_ff <= (9'(req_column) < 9'(w_act)) && (9'(req_row) < 9'(h_act));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bit_pkg::ST_IDLE:
            if (start) begin
               unique case (bit_pkg::cmd_type'(req_command))
                  bit_pkg::CMD_WRITE: state_in = bit_pkg::ST_DONE;
                  bit_pkg::CMD_READ:  state_in = bit_pkg::ST_RDPIX;
                  default:            state_in = bit_pkg::ST_COPY;
               endcase
            end
         bit_pkg::ST_RDPIX:   state_in = bit_pkg::ST_RDWAIT;
         bit_pkg::ST_RDWAIT:  state_in = bit_pkg::ST_DONE;
         bit_pkg::ST_COPY:    state_in = bit_pkg::ST_COPYW;
         bit_pkg::ST_COPYW:
            state_in = (x_last && y_last) ? bit_pkg::ST_PIX : bit_pkg::ST_COPY;
         bit_pkg::ST_PIX:     state_in = bit_pkg::ST_NBR;
         bit_pkg::ST_NBR:
            if (cell_ff == 4'd9 || !match_ff) state_in = bit_pkg::ST_WR;
            else if (code[1]) state_in = bit_pkg::ST_NBR;
            else state_in = bit_pkg::ST_NBRW;
         bit_pkg::ST_NBRW:    state_in = bit_pkg::ST_NBR;
         bit_pkg::ST_WR:
            state_in = (x_last && y_last) ? bit_pkg::ST_PASSEND : bit_pkg::ST_PIX;
         bit_pkg::ST_PASSEND:
            if (cmd_ff == bit_pkg::CMD_HAM) state_in = bit_pkg::ST_DONE;
            else if (sub_ff != 3'd7) state_in = bit_pkg::ST_COPY;
            else if (round_changed_ff) state_in = bit_pkg::ST_COPY;
            else state_in = bit_pkg::ST_DONE;
         bit_pkg::ST_DONE:    state_in = bit_pkg::ST_IDLE;
         default:             state_in = bit_pkg::ST_IDLE;
      endcase
   end

   // Datapath next values and memory controls.
   always_comb begin
      x_in = x_ff; y_in = y_ff; cell_in = cell_ff; sub_in = sub_ff;
      match_in = match_ff; old_in = old_ff; any_in = any_ff;
      round_changed_in = round_changed_ff; pix_in = pix_ff;
      img_we = 1'b0; snp_we = 1'b0; img_wd = val_ff;
      img_addr = {YW'(row_ff), XW'(col_ff)};
      snp_addr = {y_ff, x_ff};
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         bit_pkg::ST_IDLE: begin
            x_in = '0; y_in = '0; sub_in = '0; any_in = 1'b0; pix_in = 1'b0;
            round_changed_in = 1'b0;
         end
         bit_pkg::ST_RDPIX: ;
         bit_pkg::ST_RDWAIT: pix_in = in_area_ff & img_rd;
         bit_pkg::ST_COPY: img_addr = {y_ff, x_ff};
         bit_pkg::ST_COPYW: begin
            snp_we = 1'b1;
            if (x_last) begin
               x_in = '0;
               y_in = y_last ? '0 : y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         bit_pkg::ST_PIX: begin
            cell_in = '0; match_in = 1'b1;
         end
         bit_pkg::ST_NBR: begin
            if (cell_ff == 4'd0) old_in = snp_rd;
            if (cell_ff != 4'd9 && match_ff) begin
               snp_addr = {ny, nx};
               if (code[1]) cell_in = cell_ff + 4'd1;
            end
         end
         bit_pkg::ST_NBRW: begin
            snp_addr = {ny, nx};
            if (snp_rd != code[0]) match_in = 1'b0;
            if (cell_ff == 4'd4) old_in = snp_rd;
            cell_in = cell_ff + 4'd1;
         end
         bit_pkg::ST_WR: begin
            img_we = 1'b1; img_addr = {y_ff, x_ff}; img_wd = nv;
            snp_addr = {y_ff, x_ff};
            if (nv != old_ff) begin
               any_in = 1'b1; round_changed_in = 1'b1;
            end
            if (x_last) begin
               x_in = '0;
               y_in = y_last ? '0 : y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         bit_pkg::ST_PASSEND: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd7) round_changed_in = 1'b0;
         end
         bit_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (cmd_ff == bit_pkg::CMD_WRITE) img_we = in_area_ff;
         end
         default: ;
      endcase
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bit_pkg::ST_IDLE;
         round_changed_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_changed_ff <= round_changed_in;
         rsp_valid <= rsp_valid_in;
      end
      x_ff <= x_in; y_ff <= y_in; cell_ff <= cell_in; sub_ff <= sub_in;
      match_ff <= match_in; old_ff <= old_in; any_ff <= any_in; pix_ff <= pix_in;
      rsp_pixel_out <= rsp_valid_in & pix_ff;
      rsp_image_changed <= rsp_valid_in & any_ff;
   end

   assign busy = (state_ff != bit_pkg::ST_IDLE);

   // The snapshot read of the center pixel is issued in the first cycle of
   // each pixel, so the old value is taken at the start of the walk.
   bit_ram #(.WIDTH(1), .DEPTH(2 ** AW)) u_image (
      .clock(clock), .wr_en(img_we), .addr(img_addr), .wr_data(img_wd),
      .rd_data(img_rd)
   );
   bit_ram #(.WIDTH(1), .DEPTH(2 ** AW)) u_snapshot (
      .clock(clock), .wr_en(snp_we), .addr(snp_addr), .wr_data(img_rd),
      .rd_data(snp_rd)
   );

   `BIT_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == bit_pkg::ST_DONE, rsp_valid)
   `BIT_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_valid, state_ff == bit_pkg::ST_IDLE)
   `BIT_ASSERT_IMP(a_rw_nochange, clock, reset, rsp_valid && cmd_ff[1] == 1'b0, !rsp_image_changed)
   `BIT_ASSERT_NEXT(a_accept, clock, reset, start && !busy, busy)
endmodule
`default_nettype wire

[hw/rtl/bit_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module bit_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word and read one word a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
